### rtl/core/capg_pkg.sv
// Shared types and constants for the circle arc point generator.
// No dependencies; compiled first.
package capg_pkg;

	localparam int CAPG_CORDIC_STAGES = 24;
	localparam logic [24:0] CAPG_MAX_POINTS = 25'd65536;

	// radius times CORDIC gain 0.60725, Q0.32
	localparam logic [31:0] CAPG_GAIN = 32'h9B74EDA8;

	localparam int CAPG_X0_W = 39;  // prescaled radius, 8 guard bits
	localparam int CAPG_XY_W = 42;  // rotation datapath
	localparam int CAPG_Z_W  = 33;  // residual angle
	localparam int CAPG_RND_W = 34; // rounded, before center add

	localparam int CAPG_CFG_IDX_W = 4;

	localparam logic [CAPG_CFG_IDX_W-1:0] REG_ANGLE_START = 4'd0;
	localparam logic [CAPG_CFG_IDX_W-1:0] REG_ANGLE_STEP  = 4'd1;
	localparam logic [CAPG_CFG_IDX_W-1:0] REG_POINT_COUNT = 4'd2;
	localparam logic [CAPG_CFG_IDX_W-1:0] REG_RADIUS      = 4'd3;
	localparam logic [CAPG_CFG_IDX_W-1:0] REG_CENTER_X    = 4'd4;
	localparam logic [CAPG_CFG_IDX_W-1:0] REG_CENTER_Y    = 4'd5;
	localparam logic [CAPG_CFG_IDX_W-1:0] REG_HEIGHT      = 4'd6;
	localparam logic [CAPG_CFG_IDX_W-1:0] REG_THREE_DIM   = 4'd7;

	// atan(2^-i) as binary angle, full turn = 2^32
	localparam logic [31:0] CAPG_ATAN [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic [15:0] point_index;
	} capg_in_t;

	typedef struct packed {
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic signed [31:0] z_coord;
		logic               point_valid;
		logic               is_last;
	} capg_out_t;

endpackage

### rtl/core/capg_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload type is supplied by the instantiating scope (see capg_pkg).
interface capg_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/circle_arc_point_generator_unit.sv
// Circle arc point generator: index -> point on arc via pipelined CORDIC.
// Depends on capg_pkg and capg_stream_if.
//
//  channel   dir   payload                                       transfer when
//  request   in    point_index                                   valid && ready
//  point     out   x_coord y_coord z_coord point_valid is_last   valid && ready
//  cfg       in    cfg_index cfg_data                            cfg_wr_en
//
// One point per clock sustained while the output is not stalled; a point passes
// two multiply/angle stages, one register per CORDIC rotation, round, center add.
// arst_n clears all stage valid bits and the registers; payload is not reset.
// Each stage advances when it is empty or the next one advances, so bubbles
// collapse and a stalled output still lets earlier stages fill.
module circle_arc_point_generator_unit #(
	parameter int CORDIC_STAGES = capg_pkg::CAPG_CORDIC_STAGES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	capg_stream_if.sink                         request,
	capg_stream_if.source                       point,
	input  logic                                cfg_wr_en,
	input  logic [capg_pkg::CAPG_CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                         cfg_data
);
	import capg_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		priority if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
			r = v[31:0];
		end else if (v[34]) begin
			r = 32'sh80000000;
		end else begin
			r = 32'sh7FFFFFFF;
		end
		return r;
	endfunction

	// configuration registers
	logic [31:0]        angle_start_q;
	logic [31:0]        angle_step_q;
	logic [16:0]        point_count_q;
	logic [30:0]        radius_q;
	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;
	logic signed [31:0] height_q;
	logic               three_dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= '0;
			angle_step_q  <= '0;
			point_count_q <= '0;
			radius_q      <= '0;
			center_x_q    <= '0;
			center_y_q    <= '0;
			height_q      <= '0;
			three_dim_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ANGLE_START: angle_start_q <= cfg_data;
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				REG_POINT_COUNT: point_count_q <= cfg_data[16:0];
				REG_RADIUS:      radius_q      <= cfg_data[30:0];
				REG_CENTER_X:    center_x_q    <= cfg_data;
				REG_CENTER_Y:    center_y_q    <= cfg_data;
				REG_HEIGHT:      height_q      <= cfg_data;
				REG_THREE_DIM:   three_dim_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage enables, rippled back from the output
	logic en_s1, en_s2, en_s3, en_s4;
	logic en_c [CORDIC_STAGES+1];

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic vld_cs [CORDIC_STAGES];

	assign en_s4 = !vld_s4 || point.ready;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_c[CORDIC_STAGES] = en_s3;
	assign en_s2 = !vld_s2 || en_c[0];
	assign en_s1 = !vld_s1 || en_s2;
	assign request.ready = en_s1;

	// s1: angle product and prescaled radius
	logic [47:0] kprod;
	logic [62:0] gprod;
	logic        pv_in, last_in;

	assign kprod   = 48'(request.data.point_index) * 48'(angle_step_q);
	assign gprod   = 63'(radius_q) * 63'(CAPG_GAIN);
	assign pv_in   = (17'(request.data.point_index) < point_count_q) &&
	                 (25'(request.data.point_index) < CAPG_MAX_POINTS);
	assign last_in = (17'(request.data.point_index) + 17'd1) == point_count_q;

	logic [31:0]          kstep_s1;
	logic [CAPG_X0_W-1:0] x0_s1;
	logic                 pv_s1, last_s1;

	// s2: absolute angle, quadrant fold
	logic [31:0]                  theta;
	logic                         fold;
	logic signed [CAPG_XY_W-1:0]  x_s2;
	logic signed [CAPG_Z_W-1:0]   z_s2;
	logic                         flip_s2, pv_s2, last_s2;

	assign theta = angle_start_q + kstep_s1;
	// angle outside [-quarter, +quarter): rotate by half a turn, negate result
	assign fold  = theta[31] ^ theta[30];

	// CORDIC rotation stages
	logic signed [CAPG_XY_W-1:0] cx_cs [CORDIC_STAGES];
	logic signed [CAPG_XY_W-1:0] cy_cs [CORDIC_STAGES];
	logic signed [CAPG_Z_W-1:0]  cz_cs [CORDIC_STAGES];
	logic                        flip_cs [CORDIC_STAGES];
	logic                        pv_cs [CORDIC_STAGES];
	logic                        last_cs [CORDIC_STAGES];

	logic signed [CAPG_XY_W-1:0] cin_x [CORDIC_STAGES];
	logic signed [CAPG_XY_W-1:0] cin_y [CORDIC_STAGES];
	logic signed [CAPG_Z_W-1:0]  cin_z [CORDIC_STAGES];
	logic                        cin_flip [CORDIC_STAGES];
	logic                        cin_pv [CORDIC_STAGES];
	logic                        cin_last [CORDIC_STAGES];
	logic                        cin_vld [CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= request.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_cs[CORDIC_STAGES-1];
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kstep_s1 <= kprod[31:0];
			x0_s1    <= gprod[62:24];
			pv_s1    <= pv_in;
			last_s1  <= last_in;
		end
		if (en_s2) begin
			x_s2    <= {{(CAPG_XY_W-CAPG_X0_W){1'b0}}, x0_s1};
			z_s2    <= fold ? {~theta[31], ~theta[31], theta[30:0]}
			                : {theta[31], theta};
			flip_s2 <= fold;
			pv_s2   <= pv_s1;
			last_s2 <= last_s1;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		logic signed [CAPG_XY_W-1:0] dx, dy;
		logic signed [CAPG_Z_W-1:0]  da;

		if (i == 0) begin : g_head
			assign cin_x[i]    = x_s2;
			assign cin_y[i]    = '0;
			assign cin_z[i]    = z_s2;
			assign cin_flip[i] = flip_s2;
			assign cin_pv[i]   = pv_s2;
			assign cin_last[i] = last_s2;
			assign cin_vld[i]  = vld_s2;
		end else begin : g_link
			assign cin_x[i]    = cx_cs[i-1];
			assign cin_y[i]    = cy_cs[i-1];
			assign cin_z[i]    = cz_cs[i-1];
			assign cin_flip[i] = flip_cs[i-1];
			assign cin_pv[i]   = pv_cs[i-1];
			assign cin_last[i] = last_cs[i-1];
			assign cin_vld[i]  = vld_cs[i-1];
		end

		assign en_c[i] = !vld_cs[i] || en_c[i+1];
		assign dx = cin_y[i] >>> i;
		assign dy = cin_x[i] >>> i;
		assign da = $signed({1'b0, CAPG_ATAN[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_cs[i] <= 1'b0;
			end else if (en_c[i]) begin
				vld_cs[i] <= cin_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en_c[i]) begin
				if (!cin_z[i][CAPG_Z_W-1]) begin
					cx_cs[i] <= cin_x[i] - dx;
					cy_cs[i] <= cin_y[i] + dy;
					cz_cs[i] <= cin_z[i] - da;
				end else begin
					cx_cs[i] <= cin_x[i] + dx;
					cy_cs[i] <= cin_y[i] - dy;
					cz_cs[i] <= cin_z[i] + da;
				end
				flip_cs[i] <= cin_flip[i];
				pv_cs[i]   <= cin_pv[i];
				last_cs[i] <= cin_last[i];
			end
		end
	end

	// s3: undo fold, drop guard bits with round half up
	logic signed [CAPG_XY_W-1:0]  xn, yn, xr, yr;
	logic signed [CAPG_RND_W-1:0] rx_s3, ry_s3;
	logic                         pv_s3, last_s3;

	assign xn = flip_cs[CORDIC_STAGES-1] ? -cx_cs[CORDIC_STAGES-1] : cx_cs[CORDIC_STAGES-1];
	assign yn = flip_cs[CORDIC_STAGES-1] ? -cy_cs[CORDIC_STAGES-1] : cy_cs[CORDIC_STAGES-1];
	assign xr = xn + CAPG_XY_W'(128);
	assign yr = yn + CAPG_XY_W'(128);

	// s4: add center, saturate, clear fields of an invalid index
	logic signed [34:0] sx, sy;
	capg_out_t          out_s4;

	assign sx = 35'(rx_s3) + 35'(center_x_q);
	assign sy = 35'(ry_s3) + 35'(center_y_q);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rx_s3   <= xr[CAPG_XY_W-1:8];
			ry_s3   <= yr[CAPG_XY_W-1:8];
			pv_s3   <= pv_cs[CORDIC_STAGES-1];
			last_s3 <= last_cs[CORDIC_STAGES-1];
		end
		if (en_s4) begin
			if (pv_s3) begin
				out_s4.x_coord     <= sat32(sx);
				out_s4.y_coord     <= sat32(sy);
				out_s4.z_coord     <= three_dim_q ? height_q : '0;
				out_s4.point_valid <= 1'b1;
				out_s4.is_last     <= last_s3;
			end else begin
				out_s4 <= '0;
			end
		end
	end

	assign point.valid = vld_s4;
	assign point.data  = out_s4;

endmodule

### rtl/core/capg_checker.sv
// Port-level checks for circle_arc_point_generator_unit, with its bind.
// Depends on the top level only through its ports.
module capg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] x_coord,
	input logic [31:0] y_coord,
	input logic [31:0] z_coord,
	input logic        point_valid,
	input logic        is_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transfer withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable({x_coord, y_coord, z_coord, point_valid, is_last}))
		else $error("output payload changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |->
		x_coord == 32'd0 && y_coord == 32'd0 && z_coord == 32'd0 && !is_last)
		else $error("invalid point carries nonzero fields");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> point_valid)
		else $error("last flag on an invalid point");

endmodule

bind circle_arc_point_generator_unit capg_checker u_capg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (point.valid),
	.out_ready   (point.ready),
	.x_coord     (point.data.x_coord),
	.y_coord     (point.data.y_coord),
	.z_coord     (point.data.z_coord),
	.point_valid (point.data.point_valid),
	.is_last     (point.data.is_last)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for circle_arc_point_generator_unit: directed table, then random arc setups.
// Depends on capg_pkg and capg_stream_if; points are checked against a local CORDIC predictor.
module tb;
	import capg_pkg::*;

	localparam int LATENCY = CAPG_CORDIC_STAGES + 4;
	localparam logic [CAPG_CFG_IDX_W-1:0] REG_UNUSED = 4'd15;
	localparam logic [31:0] ARC_GAIN = 32'h9B74EDA8;
	localparam int ARC_GUARD = 8;
	localparam capg_out_t NO_POINT = '0;

	// atan(2^-i), full turn = 2^32
	localparam logic [31:0] ARC_ATAN [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum int {
		SET_RESET, SET_POINT_RADIUS, SET_QUARTERS, SET_FOLD_POS,
		SET_FOLD_NEG, SET_EXTREME, SET_WIDE_COUNT
	} arc_setup_t;

	typedef struct {
		arc_setup_t setup;
		logic [15:0] idx;
		bit          typed;
		capg_out_t   want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CAPG_CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	capg_stream_if #(.payload_t(capg_in_t))  request_if ();
	capg_stream_if #(.payload_t(capg_out_t)) point_if ();

	circle_arc_point_generator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request_if),
		.point     (point_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the arc registers
	logic [31:0]        arc_start  = '0;
	logic [31:0]        arc_step   = '0;
	logic [16:0]        arc_count  = '0;
	logic [30:0]        arc_radius = '0;
	logic signed [31:0] arc_cx     = '0;
	logic signed [31:0] arc_cy     = '0;
	logic signed [31:0] arc_height = '0;
	logic               arc_3d     = 1'b0;

	capg_out_t arc_points_due [$];
	int failures = 0;
	bit tx_gap_en = 1'b0;
	bit rx_stall_en = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return 32'(v);
	endfunction

	// point k of the current arc
	function automatic capg_out_t arc_point(logic [15:0] k);
		logic [31:0] theta;
		bit turn;
		longint unsigned prod;
		longint vx, vy, va, dx, dy;
		capg_out_t r;
		r = NO_POINT;
		if (!(17'(k) < arc_count && 25'(k) < CAPG_MAX_POINTS))
			return r;
		theta = arc_start + 32'(k) * arc_step;
		// left half plane: rotate by half a turn, negate afterwards
		turn = theta[31] ^ theta[30];
		if (turn)
			theta[31] = ~theta[31];
		va = longint'($signed(theta));
		prod = 64'(arc_radius) * 64'(ARC_GAIN);
		vx = longint'(prod >> (32 - ARC_GUARD));
		vy = 0;
		for (int i = 0; i < CAPG_CORDIC_STAGES; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (va >= 0) begin
				vx = vx - dx;
				vy = vy + dy;
				va = va - longint'(ARC_ATAN[i]);
			end else begin
				vx = vx + dx;
				vy = vy - dy;
				va = va + longint'(ARC_ATAN[i]);
			end
		end
		if (turn) begin
			vx = -vx;
			vy = -vy;
		end
		vx = (vx + (64'sd1 <<< (ARC_GUARD - 1))) >>> ARC_GUARD;
		vy = (vy + (64'sd1 <<< (ARC_GUARD - 1))) >>> ARC_GUARD;
		r.x_coord = clamp32(vx + longint'(arc_cx));
		r.y_coord = clamp32(vy + longint'(arc_cy));
		r.z_coord = arc_3d ? arc_height : 32'sd0;
		r.point_valid = 1'b1;
		r.is_last = (17'(k) + 17'd1 == arc_count);
		return r;
	endfunction

	task automatic report_fail(input string msg);
		failures++;
		if (failures <= 20)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_fail($sformatf("%s got %h expected %h", name, got, want));
	endtask

	task automatic write_reg(input logic [CAPG_CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (idx)
			REG_ANGLE_START: arc_start = val;
			REG_ANGLE_STEP:  arc_step = val;
			REG_POINT_COUNT: arc_count = val[16:0];
			REG_RADIUS:      arc_radius = val[30:0];
			REG_CENTER_X:    arc_cx = val;
			REG_CENTER_Y:    arc_cy = val;
			REG_HEIGHT:      arc_height = val;
			REG_THREE_DIM:   arc_3d = val[0];
			default: ;
		endcase
	endtask

	// drop valid and wait for the pipeline to empty
	task automatic settle();
		request_if.valid = 1'b0;
		while (arc_points_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_point(input logic [15:0] k, input bit typed, input capg_out_t want);
		int gap;
		gap = (tx_gap_en && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			request_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		request_if.valid = 1'b1;
		request_if.data.point_index = k;
		do @(posedge clk); while (!request_if.ready);
		arc_points_due = {arc_points_due, (typed ? want : arc_point(k))};
		@(negedge clk);
	endtask

	task automatic setup_directed(input arc_setup_t s);
		case (s)
			SET_POINT_RADIUS: begin
				write_reg(REG_ANGLE_START, 32'h40000000);
				write_reg(REG_ANGLE_STEP, 32'h01234567);
				write_reg(REG_POINT_COUNT, 32'd1);
				write_reg(REG_RADIUS, 32'd0);
				write_reg(REG_CENTER_X, 32'h7FFFFFFF);
				write_reg(REG_CENTER_Y, 32'h80000000);
				write_reg(REG_HEIGHT, 32'h12345678);
				write_reg(REG_THREE_DIM, 32'd1);
			end
			SET_QUARTERS: begin
				write_reg(REG_ANGLE_START, 32'd0);
				write_reg(REG_ANGLE_STEP, 32'h40000000);
				write_reg(REG_POINT_COUNT, 32'd8);
				write_reg(REG_RADIUS, 32'h00010000);
				write_reg(REG_CENTER_X, 32'h00020000);
				write_reg(REG_CENTER_Y, 32'hFFFE0000);
				write_reg(REG_HEIGHT, 32'hFFFFFFFF);
			end
			SET_FOLD_POS: begin
				write_reg(REG_ANGLE_START, 32'h3FFFFFFF);
				write_reg(REG_ANGLE_STEP, 32'd1);
				write_reg(REG_POINT_COUNT, 32'd3);
				write_reg(REG_RADIUS, 32'h7FFFFFFF);
				write_reg(REG_CENTER_X, 32'd0);
				write_reg(REG_CENTER_Y, 32'd0);
				write_reg(REG_THREE_DIM, 32'd0);
			end
			SET_FOLD_NEG: begin
				write_reg(REG_ANGLE_START, 32'hBFFFFFFF);
				write_reg(REG_POINT_COUNT, 32'd2);
			end
			SET_EXTREME: begin
				write_reg(REG_ANGLE_START, 32'h80000000);
				write_reg(REG_ANGLE_STEP, 32'hFFFFFFFF);
				write_reg(REG_POINT_COUNT, 32'd65536);
				write_reg(REG_CENTER_X, 32'h7FFFFFFF);
				write_reg(REG_CENTER_Y, 32'h80000000);
				// unmapped index must not disturb anything
				write_reg(REG_UNUSED, 32'hFFFFFFFF);
			end
			SET_WIDE_COUNT: begin
				write_reg(REG_POINT_COUNT, 32'hFFFFFFFF);
				write_reg(REG_HEIGHT, 32'h80000000);
				write_reg(REG_THREE_DIM, 32'hFFFFFFFE);
			end
			default: ;
		endcase
	endtask

	function automatic logic [31:0] wide_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($urandom_range(0, 32'h00200000)) - 32'h00100000;
			default: return $urandom;
		endcase
	endfunction

	// upper data bits are left random to exercise register masking
	task automatic random_setup();
		logic [31:0] step, cnt, rad;
		case ($urandom_range(0, 4))
			0: step = $urandom;
			1: step = $urandom_range(0, 4096);
			2: step = 32'hFFFFFFFF;
			3: step = 32'd0;
			default: step = 32'(64'h1_0000_0000 / $urandom_range(1, 64));
		endcase
		case ($urandom_range(0, 5))
			0: cnt = 32'd0;
			1: cnt = 32'd1;
			2, 3: cnt = $urandom_range(2, 300);
			4: cnt = 32'd65536;
			default: cnt = $urandom_range(0, 131071);
		endcase
		cnt[31:17] = 15'($urandom);
		case ($urandom_range(0, 3))
			0: rad = 32'hFFFFFFFF;
			1: rad = $urandom_range(0, 32'h00400000);
			default: rad = $urandom;
		endcase
		write_reg(REG_ANGLE_START, $urandom);
		write_reg(REG_ANGLE_STEP, step);
		write_reg(REG_POINT_COUNT, cnt);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_CENTER_X, wide_value());
		write_reg(REG_CENTER_Y, wide_value());
		write_reg(REG_HEIGHT, wide_value());
		write_reg(REG_THREE_DIM, $urandom);
		if ($urandom_range(0, 3) == 0)
			write_reg(4'($urandom_range(8, 15)), $urandom);
	endtask

	function automatic logic [15:0] next_index();
		int span;
		int r;
		span = (arc_count > 17'd65536) ? 65536 : int'(arc_count);
		r = $urandom_range(0, 9);
		if (span > 0 && r < 6)
			return 16'($urandom_range(0, span - 1));
		if (span > 0 && r == 6)
			return 16'(span - 1);
		if (r == 7)
			return 16'(span);
		return 16'($urandom);
	endfunction

	// result side: random backpressure, compare every transfer
	initial begin
		int stall_left;
		capg_out_t want;
		stall_left = 0;
		point_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				point_if.ready = 1'b0;
			end else begin
				point_if.ready = 1'b1;
				if (rx_stall_en && $urandom_range(0, 4) == 0)
					stall_left = pick_gap();
			end
			@(posedge clk);
			if (arst_n && point_if.valid && point_if.ready) begin
				if (arc_points_due.size() == 0) begin
					report_fail("point transfer with nothing expected");
				end else begin
					want = arc_points_due.pop_front();
					check_field("x_coord", point_if.data.x_coord, want.x_coord);
					check_field("y_coord", point_if.data.y_coord, want.y_coord);
					check_field("z_coord", point_if.data.z_coord, want.z_coord);
					check_field("point_valid", point_if.data.point_valid, want.point_valid);
					check_field("is_last", point_if.data.is_last, want.is_last);
				end
			end
		end
	end

	initial begin
		dir_row_t directed_rows [23];
		int last_setup;
		directed_rows = '{
			'{SET_RESET,        16'd0,     1'b1, NO_POINT},
			'{SET_RESET,        16'd65535, 1'b1, NO_POINT},
			'{SET_POINT_RADIUS, 16'd0,     1'b1,
				'{32'sh7FFFFFFF, 32'sh80000000, 32'sh12345678, 1'b1, 1'b1}},
			'{SET_POINT_RADIUS, 16'd1,     1'b1, NO_POINT},
			'{SET_QUARTERS,     16'd0,     1'b0, NO_POINT},
			'{SET_QUARTERS,     16'd1,     1'b0, NO_POINT},
			'{SET_QUARTERS,     16'd2,     1'b0, NO_POINT},
			'{SET_QUARTERS,     16'd3,     1'b0, NO_POINT},
			'{SET_QUARTERS,     16'd4,     1'b0, NO_POINT},
			'{SET_QUARTERS,     16'd5,     1'b0, NO_POINT},
			'{SET_QUARTERS,     16'd6,     1'b0, NO_POINT},
			'{SET_QUARTERS,     16'd7,     1'b0, NO_POINT},
			'{SET_QUARTERS,     16'd8,     1'b1, NO_POINT},
			'{SET_FOLD_POS,     16'd0,     1'b0, NO_POINT},
			'{SET_FOLD_POS,     16'd1,     1'b0, NO_POINT},
			'{SET_FOLD_POS,     16'd2,     1'b0, NO_POINT},
			'{SET_FOLD_NEG,     16'd0,     1'b0, NO_POINT},
			'{SET_FOLD_NEG,     16'd1,     1'b0, NO_POINT},
			'{SET_EXTREME,      16'd0,     1'b0, NO_POINT},
			'{SET_EXTREME,      16'd32768, 1'b0, NO_POINT},
			'{SET_EXTREME,      16'd65535, 1'b0, NO_POINT},
			'{SET_WIDE_COUNT,   16'd65535, 1'b0, NO_POINT},
			'{SET_WIDE_COUNT,   16'd0,     1'b0, NO_POINT}
		};
		last_setup = -1;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		request_if.valid = 1'b0;
		request_if.data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_gap_en = 1'b1;
		rx_stall_en = 1'b1;
		foreach (directed_rows[i]) begin
			if (int'(directed_rows[i].setup) != last_setup) begin
				if (last_setup >= 0)
					settle();
				setup_directed(directed_rows[i].setup);
				last_setup = int'(directed_rows[i].setup);
			end
			send_point(directed_rows[i].idx, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			random_setup();
			// first random setup runs without random request gaps or output stalls
			tx_gap_en = (ph != 0) && ($urandom_range(0, 2) != 0);
			rx_stall_en = (ph != 0) && ($urandom_range(0, 2) != 0);
			for (int n = 0; n < 50; n++) begin
				if (n == 25 && (ph == 1 || $urandom_range(0, 1) == 1))
					settle();
				send_point(next_index(), 1'b0, NO_POINT);
			end
		end

		request_if.valid = 1'b0;
		while (arc_points_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
rtl/core/capg_pkg.sv
rtl/core/capg_stream_if.sv
rtl/core/circle_arc_point_generator_unit.sv
rtl/core/capg_checker.sv
tb/sv/tb.sv
